// ===== rtl/gray_level_quantizer_top_macros.svh =====
// Assertion macros shared by the quantizer RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef GRAY_LEVEL_QUANTIZER_TOP_MACROS_SVH
`define GRAY_LEVEL_QUANTIZER_TOP_MACROS_SVH

// expression must hold at every clock edge out of reset
`define GLQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define GLQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/glq_pkg.sv =====
// Package for the gray level quantizer: widths, constants and beat types.
// No dependencies; used by every other source file of the block but the macros header.
package glq_pkg;

    localparam int PIX_W   = 8;
    localparam int LVL_W   = 9;
    localparam int QUOT_W  = 8;
    localparam int NUM_W   = 17;
    localparam int DIV_W   = 9;
    localparam int PROD_W  = 16;

    localparam logic [LVL_W-1:0] LEVEL_MIN   = 9'd2;
    localparam logic [LVL_W-1:0] LEVEL_MAX   = 9'd256;
    localparam logic [LVL_W-1:0] LEVEL_RESET = 9'd16;
    localparam logic [PROD_W-1:0] HALF_SCALE = 16'd127;
    localparam logic [PROD_W-1:0] FULL_SCALE = 16'd255;

    localparam int DIV_BITS_PER_STAGE_DEF = 2;

    // dividend/divisor beat for the reconstruction divide
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DIV_W-1:0]  divisor;
        logic [QUOT_W-1:0] quot;
        logic [PIX_W-1:0]  idx;
    } glq_div_t;

    function automatic logic [LVL_W-1:0] clamp_levels(input logic [LVL_W-1:0] v);
        logic [LVL_W-1:0] r;
        if (v < LEVEL_MIN)
        begin
            r = LEVEL_MIN;
        end
        else if (v > LEVEL_MAX)
        begin
            r = LEVEL_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/glq_pix_if.sv =====
// Pixel input channel: valid/ready handshake with one gray sample per beat.
// Depends on glq_pkg.
interface glq_pix_if
    import glq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] gray_in;

    modport source (output valid, output gray_in, input ready);
    modport sink   (input valid, input gray_in, output ready);
endinterface

// ===== rtl/glq_res_if.sv =====
// Result channel: valid/ready handshake, reconstructed gray and level index.
// Depends on glq_pkg.
interface glq_res_if
    import glq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] gray_out;
    logic [PIX_W-1:0] level_index;

    modport source (output valid, output gray_out, output level_index, input ready);
    modport sink   (input valid, input gray_out, input level_index, output ready);
endinterface

// ===== rtl/glq_index.sv =====
// Level index pipeline: idx = floor((v*s + 127) / 255), then dividend 510*idx + s.
// Four register stages; depends on glq_pkg.
module glq_index
    import glq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PIX_W-1:0]  gray,
    input  logic [PIX_W-1:0]  steps,
    output logic              out_valid,
    input  logic              out_ready,
    output glq_div_t          out_data
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    logic [PROD_W-1:0] p_reg, p_next;
    logic [PIX_W-1:0]  s1_reg, s2_reg, s3_reg;
    logic [PROD_W-1:0] q_reg, q_next;
    logic [PIX_W-1:0]  e_reg, e_next;
    logic [PIX_W-1:0]  idx_reg, idx_next;
    glq_div_t          div_reg, div_next;

    logic [23:0]       recip_sum;
    logic [PROD_W-1:0] r_est;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG-2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = div_reg;

    // stage 1: v*s
    assign p_next = PROD_W'({8'd0, gray} * {8'd0, steps});

    // stage 2: q/255 estimated as q*257 >> 16, low by at most one
    assign q_next    = p_reg + HALF_SCALE;
    assign recip_sum = {8'd0, q_next} + {q_next, 8'd0};
    assign e_next    = recip_sum[23:16];

    // stage 3: one correction step, remainder is below 510
    assign r_est    = q_reg - {e_reg, 8'd0} + {8'd0, e_reg};
    assign idx_next = e_reg + PIX_W'(r_est >= FULL_SCALE);

    // stage 4: dividend 510*idx + s over divisor 2*s
    always_comb
    begin
        div_next.rem     = {idx_reg, 9'd0} - {8'd0, idx_reg, 1'b0} + {9'd0, s3_reg};
        div_next.divisor = {s3_reg, 1'b0};
        div_next.quot    = '0;
        div_next.idx     = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            p_reg  <= p_next;
            s1_reg <= steps;
        end
        if (rdy[1])
        begin
            q_reg  <= q_next;
            e_reg  <= e_next;
            s2_reg <= s1_reg;
        end
        if (rdy[2])
        begin
            idx_reg <= idx_next;
            s3_reg  <= s2_reg;
        end
        if (rdy[3])
        begin
            div_reg <= div_next;
        end
    end

endmodule

// ===== rtl/glq_divider.sv =====
// Pipelined restoring divider for the reconstructed gray value.
// BITS_PER_STAGE quotient bits per register stage; depends on glq_pkg.
`include "gray_level_quantizer_top_macros.svh"
module glq_divider
    import glq_pkg::*;
#(
    parameter int BITS_PER_STAGE = DIV_BITS_PER_STAGE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  glq_div_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIX_W-1:0]  gray,
    output logic [PIX_W-1:0]  idx
);

    localparam int NSTG = QUOT_W / BITS_PER_STAGE;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;
    glq_div_t        st_reg  [NSTG];
    glq_div_t        st_next [NSTG];

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG-2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign gray      = st_reg[NSTG-1].quot;
    assign idx       = st_reg[NSTG-1].idx;

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        glq_div_t stage_in;
        if (k == 0)
        begin : g_first
            assign stage_in = in_data;
        end
        else
        begin : g_rest
            assign stage_in = st_reg[k-1];
        end

        always_comb
        begin
            logic [NUM_W-1:0] sh;
            st_next[k] = stage_in;
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                sh = NUM_W'({8'd0, stage_in.divisor} << (QUOT_W-1 - k*BITS_PER_STAGE - j));
                if (st_next[k].rem >= sh)
                begin
                    st_next[k].rem = st_next[k].rem - sh;
                    st_next[k].quot[QUOT_W-1 - k*BITS_PER_STAGE - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    `GLQ_ASSERT_IMPLY(a_div_nonzero, in_valid, in_data.divisor >= 9'd2, "divisor below two")
    `GLQ_ASSERT_IMPLY(a_quot_fits, in_valid,
        in_data.rem < NUM_W'({8'd0, in_data.divisor} << QUOT_W), "quotient exceeds eight bits")
    `GLQ_ASSERT_IMPLY(a_rem_final, out_valid,
        st_reg[NSTG-1].rem < {8'd0, st_reg[NSTG-1].divisor}, "remainder not below divisor")

endmodule

// ===== rtl/gray_level_quantizer_top.sv =====
// Gray level quantizer: one 8-bit pixel per beat in, one (gray_out, level_index) beat out,
// sustained at one pixel per clock while res.ready stays high. Four stages form the
// level index, the rest are the pipelined divider that rebuilds the gray value. Ready
// runs back through all stages in the same cycle, so a stall only fills bubbles.
// level_count saturates to 2..256 and resets to 16.
`include "gray_level_quantizer_top_macros.svh"
module gray_level_quantizer_top
    import glq_pkg::*;
#(
    parameter int DIV_BITS_PER_STAGE = DIV_BITS_PER_STAGE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LVL_W-1:0] cfg_wdata,
    glq_pix_if.sink          pix,
    glq_res_if.source        res
);

    logic [LVL_W-1:0] level_count_reg;
    logic [LVL_W-1:0] level_count_next;
    logic [PIX_W-1:0] steps;

    logic             mid_valid;
    logic             mid_ready;
    glq_div_t         mid_data;

    assign level_count_next = clamp_levels(cfg_wdata);
    assign steps            = PIX_W'(level_count_reg - 9'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            level_count_reg <= level_count_next;
        end
    end

    glq_index u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .gray      (pix.gray_in),
        .steps     (steps),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    glq_divider #(
        .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .gray      (res.gray_out),
        .idx       (res.level_index)
    );

    `GLQ_ASSERT_ALWAYS(a_level_range,
        level_count_reg >= LEVEL_MIN && level_count_reg <= LEVEL_MAX, "level count out of range")
    `GLQ_ASSERT_IMPLY(a_index_range, res.valid,
        {1'b0, res.level_index} < level_count_reg, "level index beyond level count")
    `GLQ_ASSERT_IMPLY(a_ready_chain, res.ready, pix.ready, "input stalled while output drains")

endmodule

// ===== verif/glq_checker.sv =====
// Scoreboard for the gray level quantizer: predicts each result beat from the accepted
// pixel beat and the live level count, then compares result beats in order.
// Depends on glq_pkg and the glq_pix_if / glq_res_if interfaces.
module glq_checker
    import glq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LVL_W-1:0] cfg_wdata,
    glq_pix_if               pix,
    glq_res_if               res,
    output int               mismatches,
    output int               outstanding,
    output int               checked
);

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic [PIX_W-1:0] idx;
    } quant_t;

    logic [LVL_W-1:0] levels;
    quant_t           quant_q[$];

    // round(v*(L-1)/255), then back to round(idx*255/(L-1)), halves going up
    function automatic quant_t quantize(input logic [PIX_W-1:0] v,
                                        input logic [LVL_W-1:0] lvl);
        int unsigned pix_val;
        int unsigned steps;
        int unsigned idx;
        int unsigned gray;
        quant_t      q;
        pix_val = v;
        steps   = lvl;
        steps   = steps - 1;
        idx     = (2 * pix_val * steps + 255) / 510;
        gray    = (510 * idx + steps) / (2 * steps);
        if (idx > steps)
        begin
            idx = steps;
        end
        if (gray > 255)
        begin
            gray = 255;
        end
        q.gray = gray[PIX_W-1:0];
        q.idx  = idx[PIX_W-1:0];
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
        begin
            $display("mismatch on %s: got %0d, want %0d (result beat %0d)",
                     what, got, want, checked);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        quant_t want;
        if (!rst_n)
        begin
            levels <= LEVEL_RESET;
            quant_q.delete();
            outstanding <= 0;
            mismatches = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_wdata < LEVEL_MIN)
                begin
                    levels <= LEVEL_MIN;
                end
                else if (cfg_wdata > LEVEL_MAX)
                begin
                    levels <= LEVEL_MAX;
                end
                else
                begin
                    levels <= cfg_wdata;
                end
            end
            if (pix.valid && pix.ready)
            begin
                quant_q.push_back(quantize(pix.gray_in, levels));
            end
            if (res.valid && res.ready)
            begin
                if (quant_q.size() == 0)
                begin
                    report_mismatch("unexpected beat, gray_out", res.gray_out, -1);
                end
                else
                begin
                    want = quant_q.pop_front();
                    if (res.gray_out !== want.gray)
                    begin
                        report_mismatch("gray_out", res.gray_out, want.gray);
                    end
                    if (res.level_index !== want.idx)
                    begin
                        report_mismatch("level_index", res.level_index, want.idx);
                    end
                end
                checked++;
            end
            outstanding <= quant_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for gray_level_quantizer_top: clock, reset, pixel stimulus,
// result back-pressure, level count writes and the verdict.
// Depends on glq_pkg, the channel interfaces, the RTL top and glq_checker.
module tb_top;
    import glq_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_PIXELS  = 100;
    localparam int NUM_PHASES    = 12;
    localparam int SETTLE_CYCLES = 24;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LVL_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int checked;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_reqs     = 0;
    int cycles        = 0;
    int pixels_sent   = 0;
    int settings_used = 0;

    glq_pix_if pix();
    glq_res_if res();

    gray_level_quantizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix       (pix),
        .res       (res)
    );

    glq_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pix         (pix),
        .res         (res),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timed out after %0d cycles, %0d results pending", cycles, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // valid stays high across back-to-back beats; idle cycles drop it
    task automatic send_pixel(input logic [PIX_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid   <= 1'b1;
        pix.gray_in <= v;
        do
        begin
            @(posedge clk);
        end
        while (!pix.ready);
        pixels_sent++;
    endtask

    // polls after an edge, so outstanding includes the last accepted beat
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_levels(input logic [LVL_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [LVL_W-1:0] phase_levels [NUM_PHASES];
        logic [PIX_W-1:0] v;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        pix.valid   = 1'b0;
        pix.gray_in = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset level count of 16
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd254);
        send_pixel(8'd255);
        // three levels: middle index rebuilds to 127.5, rounds up
        write_levels(9'd3);
        send_pixel(8'd64);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd191);
        // zero saturates to two levels
        write_levels(9'd0);
        send_pixel(8'd0);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd255);
        // all ones saturates to 256 levels
        write_levels(9'd511);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd255);
        write_levels(9'd1);
        send_pixel(8'd255);
        write_levels(9'd257);
        send_pixel(8'd1);
        send_pixel(8'd254);

        phase_levels = '{9'd2, 9'd256, 9'd3, 9'd255, 9'd0, 9'd300,
                         9'd128, 9'd17, 9'd1, 9'd4, 9'd2, 9'd256};
        phase_levels[3] = LVL_W'($urandom_range(255, 5));
        phase_levels[9] = LVL_W'($urandom_range(64, 5));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_levels(phase_levels[ph]);
            tx_idle_pct = (ph < 4) ? 10 : (ph < 8) ? 55 : 0;
            rx_idle_pct <= (ph < 4) ? 55 : (ph < 8) ? 10 : 0;
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                if (ph == 1 && n == 40)
                begin
                    hold_reqs <= hold_reqs + 1;
                end
                if (ph == 5 && n == 50)
                begin
                    wait_idle();
                end
                v = PIX_W'($urandom_range(255));
                // lean on the rails and the midpoint now and then
                case ($urandom_range(15))
                    0: v = 8'd0;
                    1: v = 8'd255;
                    2: v = 8'd127;
                    3: v = 8'd128;
                    default: ;
                endcase
                send_pixel(v);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d pixels over %0d level count writes, saturating ones included;",
                 pixels_sent, settings_used);
        $display("%0d result beats checked under mixed stalls and a %0d-cycle hold-off",
                 checked, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/glq_pkg.sv
rtl/glq_pix_if.sv
rtl/glq_res_if.sv
rtl/glq_index.sv
rtl/glq_divider.sv
rtl/gray_level_quantizer_top.sv
verif/glq_checker.sv
verif/tb_top.sv
